// ===== hw/rtl/spo_pkg.sv =====
package spo_pkg;

	// Store geometry
	localparam int unsigned MAX_LEN = 64;
	localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
	localparam int unsigned ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// Item field widths
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned OUT_W    = 7;
	localparam int unsigned OUT_BUS_W = ((OUT_W + 7) / 8) * 8;

	// Operation codes carried in the input tuser
	localparam logic [FUNC_W-1:0] FUNC_APPEND_FIRST  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND_SECOND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE       = 2'd2;

	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [VALUE_W-1:0] elem_t;

endpackage

// ===== hw/rtl/spo_ram.sv =====
module spo_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/suffix_prefix_overlap_length.sv =====
// Append items are accepted back to back, one per cycle, while no compute item is in progress.
// A compute item walks candidate lengths k from min(first, second) down to 1,
// one element compare per cycle through the single read port of each store;
// a failed k restarts the walk at k-1, and the result is loaded into the output
// register once the walk ends and that register is free, input held off until then.
// The result waits in an output register; appends are taken while it waits.
// Reset clears counts, the overflow flag and all valids; store contents stay unknown.
module suffix_prefix_overlap_length (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [spo_pkg::VALUE_W-1:0]          s_axis_tdata,  // [31:0] value
	input  logic [spo_pkg::FUNC_W-1:0]           s_axis_tuser,  // [1:0] func
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [spo_pkg::OUT_BUS_W-1:0]        m_axis_tdata,  // [6:0] overlap_length
	output logic                                 m_axis_tuser   // [0] overflow
);

	import spo_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_DRAIN
	} state_t;

	state_t state_q;
	cnt_t   first_count_q;
	cnt_t   second_count_q;
	logic   dropped_q;
	cnt_t   k_q;
	cnt_t   j_q;
	cnt_t   res_q;
	logic   v_s1;
	logic   last_s1;
	logic   m_valid_q;
	logic [OUT_W-1:0] m_len_q;
	logic   m_ovf_q;

	logic   in_acc;
	logic   out_free;
	logic   first_full;
	logic   second_full;
	logic   we_first;
	logic   we_second;
	cnt_t   k_start;
	cnt_t   a_idx;
	addr_t  a_raddr;
	addr_t  b_raddr;
	elem_t  a_rdata;
	elem_t  b_rdata;
	logic   mismatch;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_BUS_W'(m_len_q);
	assign m_axis_tuser  = m_ovf_q;

	// Append enables: drop when the store is full
	assign first_full  = (first_count_q == cnt_t'(MAX_LEN));
	assign second_full = (second_count_q == cnt_t'(MAX_LEN));
	assign we_first    = in_acc && (s_axis_tuser == FUNC_APPEND_FIRST) && !first_full;
	assign we_second   = in_acc && (s_axis_tuser == FUNC_APPEND_SECOND) && !second_full;

	// Longest candidate overlap
	assign k_start = (first_count_q < second_count_q) ? first_count_q : second_count_q;

	// Compare addresses: first[na - k + j] against second[j]
	assign a_idx   = first_count_q - k_q + j_q;
	assign a_raddr = a_idx[ADDR_W-1:0];
	assign b_raddr = j_q[ADDR_W-1:0];

	spo_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_LEN)
	) u_first_ram (
		.clk   (clk),
		.we    (we_first),
		.waddr (first_count_q[ADDR_W-1:0]),
		.wdata (s_axis_tdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	spo_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_LEN)
	) u_second_ram (
		.clk   (clk),
		.we    (we_second),
		.waddr (second_count_q[ADDR_W-1:0]),
		.wdata (s_axis_tdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	assign mismatch = (a_rdata != b_rdata);

	// Sequence appends, the compare walk and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			first_count_q  <= '0;
			second_count_q <= '0;
			dropped_q      <= 1'b0;
			k_q            <= '0;
			j_q            <= '0;
			res_q          <= '0;
			v_s1           <= 1'b0;
			last_s1        <= 1'b0;
			m_valid_q      <= 1'b0;
			m_len_q        <= '0;
			m_ovf_q        <= 1'b0;
		end else begin
			// Retire the held item; a hand-off in ST_DRAIN reloads it instead
			if (m_valid_q && m_axis_tready && (state_q != ST_DRAIN)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (s_axis_tuser)
							FUNC_APPEND_FIRST: begin
								if (first_full) dropped_q <= 1'b1;
								else first_count_q <= first_count_q + 1'b1;
							end
							FUNC_APPEND_SECOND: begin
								if (second_full) dropped_q <= 1'b1;
								else second_count_q <= second_count_q + 1'b1;
							end
							FUNC_COMPUTE: begin
								k_q     <= k_start;
								j_q     <= '0;
								v_s1    <= 1'b0;
								state_q <= ST_COMPARE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_COMPARE: begin
					if (v_s1 && mismatch) begin
						// Drop this length, restart at the next shorter one
						k_q  <= k_q - 1'b1;
						j_q  <= '0;
						v_s1 <= 1'b0;
					end else if (v_s1 && last_s1) begin
						res_q   <= k_q;
						v_s1    <= 1'b0;
						state_q <= ST_DRAIN;
					end else if (k_q == '0) begin
						res_q   <= '0;
						v_s1    <= 1'b0;
						state_q <= ST_DRAIN;
					end else if (j_q != k_q) begin
						// Issue the next element pair
						v_s1    <= 1'b1;
						last_s1 <= (j_q == k_q - 1'b1);
						j_q     <= j_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						m_valid_q      <= 1'b1;
						m_len_q        <= OUT_W'(res_q);
						m_ovf_q        <= dropped_q;
						first_count_q  <= '0;
						second_count_q <= '0;
						dropped_q      <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Counts never pass the store depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(first_count_q <= cnt_t'(MAX_LEN)) && (second_count_q <= cnt_t'(MAX_LEN)))
		else $error("store count beyond depth");

	// Walk stays inside the shorter sequence
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |-> (k_q <= k_start) && (j_q <= k_q))
		else $error("compare walk out of bounds");

	// A compare in flight only exists during the walk
	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_COMPARE))
		else $error("compare pending outside walk");

	// Handing off a result clears the sequences and raises tvalid
	a_drain_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRAIN) && out_free) |=>
			(first_count_q == '0) && (second_count_q == '0) && m_axis_tvalid && !dropped_q)
		else $error("result hand-off did not clear state");

	// Output length never exceeds the shorter sequence
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (res_q <= k_start))
		else $error("overlap longer than shorter sequence");

endmodule
